/* hdl/ludpp_pkg.sv */
// Shared constants, types and helpers for the LU decomposition unit.
`timescale 1ns / 1ps

package ludpp_pkg;

	localparam int MAX_ORDER_DEF = 8;
	localparam int DATA_W        = 32;
	localparam int FRAC_W        = 24;
	localparam int PORT_IW       = 3;
	localparam int SIZE_W        = 4;
	localparam int PIVOT_W       = 16;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 16;
	localparam int MUL_W         = DATA_W + 1;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int ACC_W         = PROD_W - FRAC_W;
	localparam int DIV_NUM_W     = DATA_W + FRAC_W + 1;
	localparam int DIV_CNT_W     = $clog2(DIV_NUM_W);

	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_PIVOT = CFG_IDX_W'(1);

	localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(4);
	localparam logic [PIVOT_W-1:0] PIVOT_RESET = PIVOT_W'(1);

	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] num;
		logic signed [DATA_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] quot;
	} div_rsp_t;

	// clamp a wide signed value to the data range
	function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){v[DATA_W-1]}}) begin
			r = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
	endfunction

endpackage

/* hdl/lu_decompose_partial_pivot_unit.sv */
// Crout LU decomposition with implicit partial pivoting: top level and sequencer.
`timescale 1ns / 1ps

// Load an n-by-n signed Q8.24 matrix row-major, one element per cycle while
// in_stall is low. After the last element the unit factors the matrix in
// place and then stalls its input until every result has been transferred.
// All products go through one multiplier and all quotients through one
// bit-serial divider, both sharing a matrix memory with one write and one
// read port: each multiply-accumulate reads both operands, multiplies and
// then accumulates, each pivot comparison adds two multiply states and a
// compare, each row swap reads and writes back both rows column by column,
// and each division yields one quotient bit per cycle. A result is read
// from memory only after the previous one has been taken. An all-zero row
// yields one result flagged singular and last instead of the factors.
module lu_decompose_partial_pivot_unit #(
	parameter int MAX_ORDER = ludpp_pkg::MAX_ORDER_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ludpp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ludpp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [ludpp_pkg::DATA_W-1:0]    element_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [ludpp_pkg::DATA_W-1:0]    lu_value,
	output logic [ludpp_pkg::PORT_IW-1:0]          row_index,
	output logic [ludpp_pkg::PORT_IW-1:0]          col_index,
	output logic [ludpp_pkg::PORT_IW-1:0]          pivot_row,
	output logic                                   singular,
	output logic                                   last
);

	localparam int IW = $clog2(MAX_ORDER);
	localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);
	localparam int DW = ludpp_pkg::DATA_W;
	localparam int MW = ludpp_pkg::MUL_W;
	localparam int PW = ludpp_pkg::PROD_W;
	localparam int SW = ludpp_pkg::SIZE_W;

	typedef enum logic [23:0] {
		ST_IDLE     = 24'h000001,
		ST_EL_RD    = 24'h000002,
		ST_EL_LD    = 24'h000004,
		ST_K_RDA    = 24'h000008,
		ST_K_RDB    = 24'h000010,
		ST_K_MUL    = 24'h000020,
		ST_K_ACC    = 24'h000040,
		ST_EL_WR    = 24'h000080,
		ST_CMP_A    = 24'h000100,
		ST_CMP_B    = 24'h000200,
		ST_CMP_C    = 24'h000400,
		ST_PIV      = 24'h000800,
		ST_SW_RDA   = 24'h001000,
		ST_SW_RDB   = 24'h002000,
		ST_SW_WRA   = 24'h004000,
		ST_SW_WRB   = 24'h008000,
		ST_PV_RD    = 24'h010000,
		ST_PV_LD    = 24'h020000,
		ST_DV_RD    = 24'h040000,
		ST_DV_GO    = 24'h080000,
		ST_DV_WAIT  = 24'h100000,
		ST_OUT_RD   = 24'h200000,
		ST_OUT_LD   = 24'h400000,
		ST_OUT_WAIT = 24'h800000
	} state_t;

	state_t state_q;

	logic [SW-1:0]                    size_q;
	logic [ludpp_pkg::PIVOT_W-1:0]    sp_q;
	logic [IW-1:0]                    row_ld_q, col_ld_q;
	logic [IW-1:0]                    i_q, j_q, k_q, kend_q, best_q;
	logic                             sing_q;
	logic                             out_valid_q;

	logic signed [DW-1:0]             s_q, a_q, t_q, piv_q;
	logic [DW-1:0]                    scale_q [MAX_ORDER];
	logic [IW-1:0]                    pivot_q [MAX_ORDER];
	logic [DW-1:0]                    best_s_q, best_m_q;
	logic [2*DW-1:0]                  cmp_a_q;
	logic signed [DW-1:0]             out_lu_q;
	logic [IW-1:0]                    out_row_q, out_col_q, out_piv_q;
	logic                             out_sing_q, out_last_q;

	logic [SW-1:0]                    ord_w;
	logic [IW-1:0]                    ord_m1;
	logic signed [DW-1:0]             sub_pivot;
	logic                             in_acc;
	logic [DW-1:0]                    in_mag, cur_max, s_mag;
	logic                             load_done, sing_next;
	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr, ram_raddr;
	logic signed [DW-1:0]             ram_wdata, ram_rdata;
	logic signed [MW-1:0]             mul_a, mul_b;
	logic signed [PW-1:0]             prod_s1;
	logic signed [PW-1:0]             rnd_sum;
	logic signed [ludpp_pkg::ACC_W-1:0] acc_diff;
	logic                             win;
	ludpp_pkg::div_req_t              div_req;
	ludpp_pkg::div_rsp_t              div_rsp;

	function automatic logic [AW-1:0] adr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return AW'(int'(r) * MAX_ORDER + int'(c));
	endfunction

	// clamp the configured order to 1..MAX_ORDER
	always_comb begin
		if (size_q == '0) begin
			ord_w = SW'(1);
		end else if (32'(size_q) > 32'(MAX_ORDER)) begin
			ord_w = SW'(MAX_ORDER);
		end else begin
			ord_w = size_q;
		end
	end
	assign ord_m1    = IW'(ord_w - SW'(1));
	assign sub_pivot = (sp_q == '0) ? DW'(1) : DW'(sp_q);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign in_mag    = ludpp_pkg::mag(element_value);
	assign cur_max   = (col_ld_q == '0 || in_mag > scale_q[row_ld_q]) ? in_mag
	                   : scale_q[row_ld_q];
	assign load_done = (row_ld_q == ord_m1) && (col_ld_q == ord_m1);
	assign sing_next = ((row_ld_q == '0 && col_ld_q == '0) ? 1'b0 : sing_q)
	                   | ((col_ld_q == ord_m1) && (cur_max == '0));
	assign s_mag     = ludpp_pkg::mag(s_q);

	// round the product to nearest (half up) and subtract
	assign rnd_sum  = prod_s1 + PW'(1 << (ludpp_pkg::FRAC_W - 1));
	assign acc_diff = ludpp_pkg::ACC_W'(s_q) - rnd_sum[PW-1:ludpp_pkg::FRAC_W];
	assign win      = (cmp_a_q >= prod_s1[2*DW-1:0]);

	assign div_req.start = (state_q == ST_DV_GO);
	assign div_req.num   = ram_rdata;
	assign div_req.den   = piv_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = adr(i_q, j_q);
		ram_wdata = s_q;
		ram_raddr = adr(i_q, j_q);
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				ram_we    = in_acc;
				ram_waddr = adr(row_ld_q, col_ld_q);
				ram_wdata = element_value;
			end
			ST_K_RDA: ram_raddr = adr(i_q, k_q);
			ST_K_RDB: ram_raddr = adr(k_q, j_q);
			ST_K_MUL: begin
				mul_a = MW'(a_q);
				mul_b = MW'(ram_rdata);
			end
			ST_EL_WR: ram_we = 1'b1;
			ST_CMP_A: begin
				mul_a = MW'({1'b0, s_mag});
				mul_b = MW'({1'b0, best_m_q});
			end
			ST_CMP_B: begin
				mul_a = MW'({1'b0, best_s_q});
				mul_b = MW'({1'b0, scale_q[i_q]});
			end
			ST_SW_RDA: ram_raddr = adr(j_q, k_q);
			ST_SW_RDB: ram_raddr = adr(best_q, k_q);
			ST_SW_WRA: begin
				ram_we    = 1'b1;
				ram_waddr = adr(j_q, k_q);
				ram_wdata = ram_rdata;
			end
			ST_SW_WRB: begin
				ram_we    = 1'b1;
				ram_waddr = adr(best_q, k_q);
				ram_wdata = t_q;
			end
			ST_PV_RD: ram_raddr = adr(j_q, j_q);
			ST_PV_LD: begin
				ram_we    = (ram_rdata == '0);
				ram_waddr = adr(j_q, j_q);
				ram_wdata = sub_pivot;
			end
			ST_DV_WAIT: begin
				ram_we    = div_rsp.done;
				ram_wdata = div_rsp.quot;
			end
			ST_OUT_RD: ram_raddr = adr(i_q, k_q);
			default: ;
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= ludpp_pkg::SIZE_RESET;
			sp_q        <= ludpp_pkg::PIVOT_RESET;
			row_ld_q    <= '0;
			col_ld_q    <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			kend_q      <= '0;
			best_q      <= '0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ludpp_pkg::CFG_MATRIX_SIZE) begin
					size_q   <= cfg_data[SW-1:0];
					row_ld_q <= '0;
					col_ld_q <= '0;
				end else if (cfg_index == ludpp_pkg::CFG_SMALL_PIVOT) begin
					sp_q <= cfg_data[ludpp_pkg::PIVOT_W-1:0];
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sing_q <= sing_next;
						if (col_ld_q == ord_m1) begin
							col_ld_q <= '0;
							row_ld_q <= (row_ld_q == ord_m1) ? '0 : row_ld_q + IW'(1);
						end else begin
							col_ld_q <= col_ld_q + IW'(1);
						end
						if (load_done) begin
							if (sing_next) begin
								out_valid_q <= 1'b1;
								state_q     <= ST_OUT_WAIT;
							end else begin
								i_q     <= '0;
								j_q     <= '0;
								state_q <= ST_EL_RD;
							end
						end
					end
				end
				ST_EL_RD: begin
					kend_q  <= (i_q < j_q) ? i_q : j_q;
					k_q     <= '0;
					state_q <= ST_EL_LD;
				end
				ST_EL_LD: state_q <= (kend_q == '0) ? ST_EL_WR : ST_K_RDA;
				ST_K_RDA: state_q <= ST_K_RDB;
				ST_K_RDB: state_q <= ST_K_MUL;
				ST_K_MUL: state_q <= ST_K_ACC;
				ST_K_ACC: begin
					if (k_q == kend_q - IW'(1)) begin
						state_q <= ST_EL_WR;
					end else begin
						k_q     <= k_q + IW'(1);
						state_q <= ST_K_RDA;
					end
				end
				ST_EL_WR: begin
					if (i_q < j_q) begin
						i_q     <= i_q + IW'(1);
						state_q <= ST_EL_RD;
					end else if (i_q == j_q) begin
						best_q <= i_q;
						if (i_q == ord_m1) begin
							state_q <= ST_PIV;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= ST_EL_RD;
						end
					end else begin
						state_q <= ST_CMP_A;
					end
				end
				ST_CMP_A: state_q <= ST_CMP_B;
				ST_CMP_B: state_q <= ST_CMP_C;
				ST_CMP_C: begin
					// ties go to the later row
					if (win) begin
						best_q <= i_q;
					end
					if (i_q == ord_m1) begin
						state_q <= ST_PIV;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= ST_EL_RD;
					end
				end
				ST_PIV: begin
					k_q     <= '0;
					state_q <= (best_q != j_q) ? ST_SW_RDA : ST_PV_RD;
				end
				ST_SW_RDA: state_q <= ST_SW_RDB;
				ST_SW_RDB: state_q <= ST_SW_WRA;
				ST_SW_WRA: state_q <= ST_SW_WRB;
				ST_SW_WRB: begin
					if (k_q == ord_m1) begin
						state_q <= ST_PV_RD;
					end else begin
						k_q     <= k_q + IW'(1);
						state_q <= ST_SW_RDA;
					end
				end
				ST_PV_RD: state_q <= ST_PV_LD;
				ST_PV_LD: begin
					if (j_q == ord_m1) begin
						i_q     <= '0;
						k_q     <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						i_q     <= j_q + IW'(1);
						state_q <= ST_DV_RD;
					end
				end
				ST_DV_RD: state_q <= ST_DV_GO;
				ST_DV_GO: state_q <= ST_DV_WAIT;
				ST_DV_WAIT: begin
					if (div_rsp.done) begin
						if (i_q == ord_m1) begin
							i_q     <= '0;
							j_q     <= j_q + IW'(1);
							state_q <= ST_EL_RD;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= ST_DV_RD;
						end
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_LD;
				ST_OUT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							if (k_q == ord_m1) begin
								k_q <= '0;
								i_q <= i_q + IW'(1);
							end else begin
								k_q <= k_q + IW'(1);
							end
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					scale_q[row_ld_q] <= cur_max;
					if (load_done && sing_next) begin
						out_lu_q   <= '0;
						out_row_q  <= '0;
						out_col_q  <= '0;
						out_piv_q  <= '0;
						out_sing_q <= 1'b1;
						out_last_q <= 1'b1;
					end
				end
			end
			ST_EL_LD: s_q <= ram_rdata;
			ST_K_RDB: a_q <= ram_rdata;
			ST_K_ACC: s_q <= ludpp_pkg::sat_acc(acc_diff);
			ST_EL_WR: begin
				if (i_q == j_q) begin
					best_s_q <= s_mag;
					best_m_q <= scale_q[i_q];
				end
			end
			ST_CMP_B: cmp_a_q <= prod_s1[2*DW-1:0];
			ST_CMP_C: begin
				if (win) begin
					best_s_q <= s_mag;
					best_m_q <= scale_q[i_q];
				end
			end
			ST_PIV: begin
				pivot_q[j_q] <= best_q;
				if (best_q != j_q) begin
					scale_q[best_q] <= scale_q[j_q];
				end
			end
			ST_SW_RDB: t_q <= ram_rdata;
			ST_PV_LD: piv_q <= (ram_rdata == '0) ? sub_pivot : ram_rdata;
			ST_OUT_LD: begin
				out_lu_q   <= ram_rdata;
				out_row_q  <= i_q;
				out_col_q  <= k_q;
				out_piv_q  <= pivot_q[i_q];
				out_sing_q <= 1'b0;
				out_last_q <= (i_q == ord_m1) && (k_q == ord_m1);
			end
			default: ;
		endcase
	end

	ludpp_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_ORDER * MAX_ORDER)
	) u_mat (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ludpp_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_s1(prod_s1)
	);

	ludpp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign out_valid = out_valid_q;
	assign lu_value  = out_lu_q;
	assign row_index = ludpp_pkg::PORT_IW'(out_row_q);
	assign col_index = ludpp_pkg::PORT_IW'(out_col_q);
	assign pivot_row = ludpp_pkg::PORT_IW'(out_piv_q);
	assign singular  = out_sing_q;
	assign last      = out_last_q;

	a_out_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_OUT_WAIT)
		else $error("result presented outside the output wait state");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DV_WAIT)
		else $error("divider finished while nobody waited for it");

	a_no_load_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !out_valid_q)
		else $error("element taken while a result is pending");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && out_last_q) |=> state_q == ST_IDLE)
		else $error("final transfer did not return to idle");

	a_singular_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_sing_q) |-> (out_last_q && out_lu_q == '0))
		else $error("singular result not flagged last with zero value");

endmodule

/* hdl/ludpp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ludpp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/ludpp_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module ludpp_mul (
	input  logic                                clk,
	input  logic signed [ludpp_pkg::MUL_W-1:0]  a,
	input  logic signed [ludpp_pkg::MUL_W-1:0]  b,
	output logic signed [ludpp_pkg::PROD_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

/* hdl/ludpp_div.sv */
// Bit-serial restoring divider: rounded Q8.24 quotient with saturation.
`timescale 1ns / 1ps

module ludpp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ludpp_pkg::div_req_t req,
	output ludpp_pkg::div_rsp_t rsp
);

	localparam int DW = ludpp_pkg::DATA_W;
	localparam int NW = ludpp_pkg::DIV_NUM_W;
	localparam int CW = ludpp_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] dvd_q;
	logic          neg_q;
	logic [DW:0]   trial;
	logic          qbit;
	logic [DW-1:0] a_mag;
	logic [DW-1:0] p_mag;

	assign a_mag = ludpp_pkg::mag(req.num);
	assign p_mag = ludpp_pkg::mag(req.den);
	assign trial = {rem_q, dvd_q[NW-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// add half the divisor so truncation rounds to nearest
			dvd_q <= NW'({a_mag, {ludpp_pkg::FRAC_W{1'b0}}}) + NW'(p_mag >> 1);
			rem_q <= '0;
			den_q <= p_mag;
			neg_q <= req.num[DW-1] ^ req.den[DW-1];
		end else if (busy_q) begin
			rem_q <= qbit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			dvd_q <= {dvd_q[NW-2:0], qbit};
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (!neg_q) begin
			if (dvd_q > NW'({1'b0, {(DW-1){1'b1}}})) begin
				rsp.quot = {1'b0, {(DW-1){1'b1}}};
			end else begin
				rsp.quot = dvd_q[DW-1:0];
			end
		end else begin
			if (dvd_q >= NW'({1'b1, {(DW-1){1'b0}}})) begin
				rsp.quot = {1'b1, {(DW-1){1'b0}}};
			end else begin
				rsp.quot = DW'(-dvd_q[DW-1:0]);
			end
		end
	end

endmodule
